/* rtl/cftr_pkg.sv */
package cftr_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_CHUNK = 2'd1;

  localparam logic [2:0] K_BEGIN     = 3'd0;
  localparam logic [2:0] K_FMT_REJ   = 3'd1;
  localparam logic [2:0] K_CHUNK     = 3'd2;
  localparam logic [2:0] K_COMMIT    = 3'd3;
  localparam logic [2:0] K_NOT_GUEST = 3'd4;

  localparam logic [2:0] ST_BEGUN      = 3'd0;
  localparam logic [2:0] ST_FMT_REJ    = 3'd1;
  localparam logic [2:0] ST_BYTE_TAKEN = 3'd2;
  localparam logic [2:0] ST_MISMATCH   = 3'd3;
  localparam logic [2:0] ST_COMMITTED  = 3'd4;
  localparam logic [2:0] ST_COMMIT_BAD = 3'd5;
  localparam logic [2:0] ST_NOT_GUEST  = 3'd6;

  localparam logic [CFG_ADDR_W-1:0] REG_GUEST_ROLE = CFG_ADDR_W'(0);

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] map_id;
    logic [31:0] transfer_id;
    logic [63:0] revision;
    logic        is_binary;
    logic        present;
    logic [31:0] metadata;
    logic [31:0] total_bytes;
    logic [63:0] expected_hash;
    logic [31:0] offset;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] done_map_id;
    logic [63:0] done_revision;
    logic [31:0] received_count;
  } out_item_t;

  typedef struct packed {
    logic [2:0] kind;
    in_item_t   item;
  } cmd_t;

  // FNV-1a 64 step; prime 0x100000001B3 as shift-adds
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

/* rtl/cftr_queue.sv */
module cftr_queue
  import cftr_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned W     = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] din,
  output logic         empty,
  input  logic         pop,
  output logic [W-1:0] dout
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && !(pop && !empty)) |=> count_r == $past(count_r) + CW'(1))
    else $error("queue count did not grow on push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

endmodule

/* rtl/cftr_front.sv */
module cftr_front
  import cftr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     guest_role,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  output logic     cmd_valid,
  input  logic     cmd_full,
  output cmd_t     cmd
);

  logic valid_r, valid_nxt;
  cmd_t cmd_r;
  cmd_t cmd_nxt;
  logic take;

  assign full      = valid_r && cmd_full;
  assign take      = push && !full;
  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  always_comb begin
    cmd_nxt.item = item;
    if (!guest_role) begin
      cmd_nxt.kind = K_NOT_GUEST;
    end else begin
      case (item.operation)
        OP_BEGIN: cmd_nxt.kind = item.is_binary ? K_BEGIN : K_FMT_REJ;
        OP_CHUNK: cmd_nxt.kind = K_CHUNK;
        default:  cmd_nxt.kind = K_COMMIT;
      endcase
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !cmd_full) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

/* rtl/cftr_back.sv */
module cftr_back
  import cftr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_pop,
  input  cmd_t      cmd,
  output logic      res_push,
  input  logic      res_full,
  output out_item_t res
);

  logic        active_r,   active_nxt;
  logic [15:0] map_id_r,   map_id_nxt;
  logic [31:0] tid_r,      tid_nxt;
  logic [63:0] rev_r,      rev_nxt;
  logic        present_r,  present_nxt;
  logic [31:0] meta_r,     meta_nxt;
  logic [31:0] total_r,    total_nxt;
  logic [63:0] exp_hash_r, exp_hash_nxt;
  logic [31:0] bytes_r,    bytes_nxt;
  logic [63:0] hash_r,     hash_nxt;

  logic     take;
  logic     hdr_ok;
  logic     chunk_ok;
  logic     commit_ok;
  in_item_t it;

  assign it       = cmd.item;
  assign take     = cmd_valid && !res_full;
  assign cmd_pop  = take;
  assign res_push = take;

  assign hdr_ok = active_r && it.map_id == map_id_r && it.transfer_id == tid_r &&
                  it.revision == rev_r && it.is_binary && it.present == present_r &&
                  it.metadata == meta_r && it.total_bytes == total_r &&
                  it.expected_hash == exp_hash_r;
  assign chunk_ok  = hdr_ok && present_r && it.offset == bytes_r && bytes_r < total_r;
  assign commit_ok = hdr_ok && it.offset == total_r && bytes_r == total_r &&
                     hash_r == exp_hash_r;

  always_comb begin
    active_nxt   = active_r;
    map_id_nxt   = map_id_r;
    tid_nxt      = tid_r;
    rev_nxt      = rev_r;
    present_nxt  = present_r;
    meta_nxt     = meta_r;
    total_nxt    = total_r;
    exp_hash_nxt = exp_hash_r;
    bytes_nxt    = bytes_r;
    hash_nxt     = hash_r;
    res          = '0;
    case (cmd.kind)
      K_NOT_GUEST: begin
        res.status = ST_NOT_GUEST;
      end
      K_BEGIN, K_FMT_REJ: begin
        active_nxt     = (cmd.kind == K_BEGIN);
        map_id_nxt     = (cmd.kind == K_BEGIN) ? it.map_id : '0;
        tid_nxt        = (cmd.kind == K_BEGIN) ? it.transfer_id : '0;
        rev_nxt        = (cmd.kind == K_BEGIN) ? it.revision : '0;
        present_nxt    = (cmd.kind == K_BEGIN) && it.present;
        meta_nxt       = (cmd.kind == K_BEGIN) ? it.metadata : '0;
        total_nxt      = (cmd.kind == K_BEGIN) ? it.total_bytes : '0;
        exp_hash_nxt   = (cmd.kind == K_BEGIN) ? it.expected_hash : '0;
        bytes_nxt      = '0;
        hash_nxt       = FNV_BASIS;
        res.status     = (cmd.kind == K_BEGIN) ? ST_BEGUN : ST_FMT_REJ;
        res.done_map_id = it.map_id;
      end
      K_CHUNK: begin
        res.done_map_id = map_id_r;
        if (chunk_ok) begin
          hash_nxt           = fnv_step(hash_r, it.data_byte);
          bytes_nxt          = bytes_r + 32'd1;
          res.status         = ST_BYTE_TAKEN;
          res.received_count = bytes_r + 32'd1;
        end else begin
          res.status = ST_MISMATCH;
        end
      end
      default: begin
        res.done_map_id = map_id_r;
        if (commit_ok) begin
          res.status         = ST_COMMITTED;
          res.done_revision  = rev_r;
          res.received_count = bytes_r;
        end else begin
          res.status = ST_COMMIT_BAD;
        end
      end
    endcase
    // failed chunk and every commit end the session
    if ((cmd.kind == K_CHUNK && !chunk_ok) || cmd.kind == K_COMMIT) begin
      active_nxt   = 1'b0;
      map_id_nxt   = '0;
      tid_nxt      = '0;
      rev_nxt      = '0;
      present_nxt  = 1'b0;
      meta_nxt     = '0;
      total_nxt    = '0;
      exp_hash_nxt = '0;
      bytes_nxt    = '0;
      hash_nxt     = FNV_BASIS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      map_id_r   <= '0;
      tid_r      <= '0;
      rev_r      <= '0;
      present_r  <= 1'b0;
      meta_r     <= '0;
      total_r    <= '0;
      exp_hash_r <= '0;
      bytes_r    <= '0;
      hash_r     <= FNV_BASIS;
    end else if (take) begin
      active_r   <= active_nxt;
      map_id_r   <= map_id_nxt;
      tid_r      <= tid_nxt;
      rev_r      <= rev_nxt;
      present_r  <= present_nxt;
      meta_r     <= meta_nxt;
      total_r    <= total_nxt;
      exp_hash_r <= exp_hash_nxt;
      bytes_r    <= bytes_nxt;
      hash_r     <= hash_nxt;
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (bytes_r == '0 && hash_r == FNV_BASIS && map_id_r == '0))
    else $error("session state left over while inactive");

  a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res.status == ST_BYTE_TAKEN) |=> bytes_r == $past(bytes_r) + 32'd1)
    else $error("byte count did not advance");

  a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (res.status == ST_COMMITTED || res.status == ST_COMMIT_BAD)) |=> !active_r)
    else $error("session survived a commit");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> bytes_r <= total_r)
    else $error("received count beyond declared total");

endmodule

/* rtl/chunked_transfer_receiver_fnv_check.sv */
// Channel   Direction  Handshake                    Payload
// input     in         push / full                  in_item  (in_item_t)
// result    out        empty / pop                  out_item (out_item_t)
// config    in/out     psel penable pwrite pready   paddr pwdata prdata (guest_role at 0)
//
// One word in and one result out per cycle when neither side stalls.
// From push to result on the queue head a word passes the front stage, the
// command queue, then the session unit writing into the result queue.
// The session unit does the header compare and FNV shift-add step in combinational logic.
// rst_n is synchronous, active low; guest_role resets to 1, session cleared.
// A stalled pop fills the result queue, then the command queue, then full rises.
module chunked_transfer_receiver_fnv_check
  import cftr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  in_item_t              in_item,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_item_t             out_item,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic guest_r;
  logic reg_sel;

  logic cmd_valid, cmd_full;
  cmd_t cmd_in, cmd_out;
  logic cmd_empty, cmd_pop;

  logic      res_push, res_full;
  out_item_t res;

  assign pready  = 1'b1;
  assign reg_sel = ({paddr[CFG_ADDR_W-1:2], 2'b00} == REG_GUEST_ROLE);
  assign prdata  = reg_sel ? {31'd0, guest_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guest_r <= 1'b1;
    end else if (psel && penable && pwrite && reg_sel) begin
      guest_r <= pwdata[0];
    end
  end

  cftr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .guest_role (guest_r),
    .push       (in_push),
    .full       (in_full),
    .item       (in_item),
    .cmd_valid  (cmd_valid),
    .cmd_full   (cmd_full),
    .cmd        (cmd_in)
  );

  cftr_queue #(
    .DEPTH (QUEUE_DEPTH),
    .W     ($bits(cmd_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_valid),
    .full  (cmd_full),
    .din   (cmd_in),
    .empty (cmd_empty),
    .pop   (cmd_pop),
    .dout  (cmd_out)
  );

  cftr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd_out),
    .res_push  (res_push),
    .res_full  (res_full),
    .res       (res)
  );

  cftr_queue #(
    .DEPTH (QUEUE_DEPTH),
    .W     ($bits(out_item_t))
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .din   (res),
    .empty (out_empty),
    .pop   (out_pop),
    .dout  (out_item)
  );

endmodule
